FILE: src/tac_pkg.sv
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants of the tomasulo alu issue core
// Request and result formats, command codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package tac_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int TAG_WIDTH       = 4;
  localparam int LAT_WIDTH       = 5;
  localparam int MAX_RESULTS     = 5;
  localparam int DEF_ADD_STATIONS = 3;
  localparam int DEF_MUL_STATIONS = 2;
  localparam int DEF_NUM_REGS     = 32;

  localparam logic [LAT_WIDTH-1:0] DADD = 5'd4;
  localparam logic [LAT_WIDTH-1:0] DSUB = 5'd6;
  localparam logic [LAT_WIDTH-1:0] DMUL = 5'd10;
  localparam logic [LAT_WIDTH-1:0] DDIV = 5'd16;

  typedef enum logic [1:0] {
    CMD_ISSUE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_EXT   = 2'd2,
    CMD_REGWR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    CFG_ADD_LAT = 2'd0,
    CFG_SUB_LAT = 2'd1,
    CFG_MUL_LAT = 2'd2,
    CFG_DIV_LAT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         alu_op;
    logic               imm_form;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [3:0]         ext_tag;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic               issue_accepted;
    logic [3:0]         station_tag;
    logic signed [31:0] bus_value;
    logic               div_zero;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic count;
    logic ext;
    logic regwr;
    logic start_calc;
    logic emit;
    logic clear_fin;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       ext_tag_zero;
    logic       out_free;
    logic       more;
    logic       calc_done;
  } sts_t;

  function automatic logic [TAG_WIDTH-1:0] tag_of(int unsigned i);
    return TAG_WIDTH'(i + 1);
  endfunction

endpackage

`default_nettype wire

FILE: src/tomasulo_alu_issue_core.sv
// ----------------------------------------------------------------------------
// tomasulo_alu_issue_core: integer reservation stations on a common data bus
// Add and multiply station groups in front of a renamed register file.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, latencies are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data while the core is quiet (cfg_ready is always 1).
// One request is handled at a time. A request is captured, then decoded; an
// issue or external broadcast then loads its response. A tick counts ready
// stations down, then for each finishing station starts, ends and emits its
// result; a divide waits for the shared one-bit-per-cycle divider.
// Results pass through one output register; while out_stall is high the
// result holds and the sequencer waits before producing the next one, so a
// new request is taken only after the previous result has been registered.
// A synchronous rst frees all stations, clears every register value and
// producer tag and restores latencies 4, 6, 10 and 16.
// ----------------------------------------------------------------------------
`default_nettype none

module tomasulo_alu_issue_core #(
  parameter int ADD_STATIONS = tac_pkg::DEF_ADD_STATIONS,
  parameter int MUL_STATIONS = tac_pkg::DEF_MUL_STATIONS,
  parameter int NUM_REGS     = tac_pkg::DEF_NUM_REGS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tac_pkg::req_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tac_pkg::rsp_t                      out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [tac_pkg::LAT_WIDTH-1:0] cfg_data
);

  tac_pkg::ctl_t ctl;
  tac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  tac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // stations and register file
  tac_dp #(
    .ADD_STATIONS (ADD_STATIONS),
    .MUL_STATIONS (MUL_STATIONS),
    .NUM_REGS     (NUM_REGS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: src/tac_ctrl.sv
// ----------------------------------------------------------------------------
// tac_ctrl: sequencing controller
// Walks each request through decode, the tick scan, execution and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module tac_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tac_pkg::sts_t  sts,
  output tac_pkg::ctl_t       ctl
);

  tac_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    unique case (state)
      tac_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = tac_pkg::ST_DECODE;
        end
      end
      tac_pkg::ST_DECODE: begin
        unique case (sts.cmd)
          tac_pkg::CMD_ISSUE: begin
            if (sts.out_free) begin
              ctl.issue  = 1'b1;
              state_next = tac_pkg::ST_IDLE;
            end
          end
          tac_pkg::CMD_TICK: begin
            ctl.count  = 1'b1;
            state_next = tac_pkg::ST_SCAN;
          end
          tac_pkg::CMD_EXT: begin
            if (sts.ext_tag_zero) begin
              state_next = tac_pkg::ST_IDLE;
            end else if (sts.out_free) begin
              ctl.ext    = 1'b1;
              state_next = tac_pkg::ST_IDLE;
            end
          end
          default: begin
            ctl.regwr  = 1'b1;
            state_next = tac_pkg::ST_IDLE;
          end
        endcase
      end
      tac_pkg::ST_SCAN: begin
        if (sts.more) begin
          ctl.start_calc = 1'b1;
          state_next     = tac_pkg::ST_CALC;
        end else begin
          ctl.clear_fin = 1'b1;
          state_next    = tac_pkg::ST_IDLE;
        end
      end
      tac_pkg::ST_CALC: begin
        if (sts.calc_done) begin
          state_next = tac_pkg::ST_EMIT;
        end
      end
      tac_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = tac_pkg::ST_SCAN;
        end
      end
      default: state_next = tac_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/tac_dp.sv
// ----------------------------------------------------------------------------
// tac_dp: stations, register file, execution unit and result register
// Carries out the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
`default_nettype none

module tac_dp #(
  parameter int ADD_STATIONS = tac_pkg::DEF_ADD_STATIONS,
  parameter int MUL_STATIONS = tac_pkg::DEF_MUL_STATIONS,
  parameter int NUM_REGS     = tac_pkg::DEF_NUM_REGS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tac_pkg::req_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tac_pkg::rsp_t                      out_data,
  input  wire logic                          cfg_valid,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [tac_pkg::LAT_WIDTH-1:0] cfg_data,
  input  wire tac_pkg::ctl_t                 ctl,
  output tac_pkg::sts_t                      sts
);

  localparam int NS = ADD_STATIONS + MUL_STATIONS;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int RW = $clog2(NUM_REGS);
  localparam int DW = tac_pkg::DATA_WIDTH;
  localparam int TW = tac_pkg::TAG_WIDTH;
  localparam int LW = tac_pkg::LAT_WIDTH;
  localparam int CW = $clog2(tac_pkg::MAX_RESULTS + 1);

  // station state
  logic [NS-1:0]       busy;
  logic [1:0]          op    [NS];
  logic [DW-1:0]       vj    [NS];
  logic [DW-1:0]       vk    [NS];
  logic [TW-1:0]       qj    [NS];
  logic [TW-1:0]       qk    [NS];
  logic [LW-1:0]       ticks [NS];
  logic [NS-1:0]       fin;
  logic [CW-1:0]       cnt;

  // register file
  logic [DW-1:0]       rv [NUM_REGS];
  logic [TW-1:0]       rq [NUM_REGS];

  logic [LW-1:0]       lat [4];
  tac_pkg::req_t       req;

  // execution
  logic [SW-1:0]       sel;
  logic [DW-1:0]       res;
  logic                res_dz;
  logic                dv_busy;
  logic [5:0]          dv_cnt;
  logic [DW-1:0]       dv_rem;
  logic [DW-1:0]       dv_quo;
  logic [DW-1:0]       dv_den;
  logic                dv_neg;
  logic                dv_zero;
  logic [DW:0]         dv_sh;
  logic [DW:0]         dv_diff;

  // source reads and free station search
  logic [DW-1:0]       s1_val, s2_val;
  logic [TW-1:0]       s1_tag, s2_tag;
  logic                free_found;
  logic [SW-1:0]       free_idx;
  logic [SW-1:0]       fin_idx;
  logic                dest_ok;
  logic [RW-1:0]       dest_idx;

  // broadcast bus
  logic                bc_en;
  logic [TW-1:0]       bc_tag;
  logic [DW-1:0]       bc_val;
  logic [NS-1:0]       bc_skip;
  logic                out_free;

  function automatic logic [DW-1:0] mag(logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // register file read port for one source
  function automatic void rd_src(input logic [4:0] r, input logic [DW-1:0] vals [NUM_REGS],
                                 input logic [TW-1:0] tags [NUM_REGS],
                                 output logic [DW-1:0] val, output logic [TW-1:0] tg);
    logic          ok;
    logic [RW-1:0] idx;
    ok  = (32'(r) < NUM_REGS);
    idx = RW'(r);
    val = '0;
    tg  = '0;
    if (ok) begin
      if (tags[idx] != '0) begin
        tg = tags[idx];
      end else begin
        val = vals[idx];
      end
    end
  endfunction

  always_comb begin
    rd_src(req.src1_reg, rv, rq, s1_val, s1_tag);
    rd_src(req.src2_reg, rv, rq, s2_val, s2_tag);
    dest_ok  = (32'(req.dest_reg) < NUM_REGS);
    dest_idx = RW'(req.dest_reg);
  end

  // lowest free station of the request's group
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (((i < ADD_STATIONS) == (req.alu_op[1] == 1'b0)) && !busy[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // lowest finished station
  always_comb begin
    fin_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (fin[i]) fin_idx = SW'(i);
    end
  end

  // divider step
  assign dv_sh   = {dv_rem, dv_quo[DW-1]};
  assign dv_diff = dv_sh - {1'b0, dv_den};

  // broadcast source
  always_comb begin
    bc_en   = ctl.emit | ctl.ext;
    bc_tag  = ctl.emit ? tac_pkg::tag_of(32'(sel)) : req.ext_tag;
    bc_val  = ctl.emit ? res : DW'(req.data_value);
    bc_skip = '0;
    if (ctl.emit) bc_skip[sel] = 1'b1;
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.cmd          = req.cmd;
    sts.ext_tag_zero = (req.ext_tag == '0);
    sts.out_free     = out_free;
    sts.more         = (|fin) && (cnt < CW'(tac_pkg::MAX_RESULTS));
    sts.calc_done    = !dv_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      fin       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      dv_busy   <= 1'b0;
      lat[0]    <= tac_pkg::DADD;
      lat[1]    <= tac_pkg::DSUB;
      lat[2]    <= tac_pkg::DMUL;
      lat[3]    <= tac_pkg::DDIV;
      for (int i = 0; i < NS; i++) begin
        qj[i]    <= '0;
        qk[i]    <= '0;
        op[i]    <= '0;
        ticks[i] <= '0;
      end
      for (int i = 0; i < NUM_REGS; i++) begin
        rv[i] <= '0;
        rq[i] <= '0;
      end
    end else begin
      // configuration write
      if (cfg_valid) lat[cfg_index] <= cfg_data;

      // result register loads or drains
      if (ctl.issue || ctl.emit || ctl.ext) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (ctl.capture) req <= in_data;

      // issue
      if (ctl.issue) begin
        out_data.kind           <= 1'b0;
        out_data.issue_accepted <= free_found;
        out_data.station_tag    <= free_found ? tac_pkg::tag_of(32'(free_idx)) : '0;
        out_data.bus_value      <= '0;
        out_data.div_zero       <= 1'b0;
        out_data.last           <= 1'b1;
        if (free_found) begin
          busy[free_idx]  <= 1'b1;
          op[free_idx]    <= req.alu_op;
          ticks[free_idx] <= lat[req.alu_op];
          vj[free_idx]    <= s1_val;
          qj[free_idx]    <= s1_tag;
          if (req.imm_form) begin
            vk[free_idx] <= DW'(req.immediate);
            qk[free_idx] <= '0;
          end else begin
            vk[free_idx] <= s2_val;
            qk[free_idx] <= s2_tag;
          end
          if (dest_ok) rq[dest_idx] <= tac_pkg::tag_of(32'(free_idx));
        end
      end

      // register value write
      if (ctl.regwr && dest_ok) rv[dest_idx] <= DW'(req.data_value);

      // tick: ready stations count down
      if (ctl.count) begin
        cnt <= '0;
        for (int i = 0; i < NS; i++) begin
          fin[i] <= busy[i] && qj[i] == '0 && qk[i] == '0 && ticks[i] <= LW'(1);
          if (busy[i] && qj[i] == '0 && qk[i] == '0) begin
            if (ticks[i] > LW'(1)) begin
              ticks[i] <= ticks[i] - 1'b1;
            end else begin
              ticks[i] <= '0;
            end
          end
        end
      end
      if (ctl.clear_fin) fin <= '0;

      // start execution of the lowest finished station
      if (ctl.start_calc) begin
        sel    <= fin_idx;
        res_dz <= 1'b0;
        unique case (op[fin_idx])
          tac_pkg::OP_ADD: res <= vj[fin_idx] + vk[fin_idx];
          tac_pkg::OP_SUB: res <= vj[fin_idx] - vk[fin_idx];
          tac_pkg::OP_MUL: res <= DW'(vj[fin_idx] * vk[fin_idx]);
          default: begin
            dv_busy <= 1'b1;
            dv_cnt  <= 6'(DW);
            dv_rem  <= '0;
            dv_quo  <= mag(vj[fin_idx]);
            dv_den  <= mag(vk[fin_idx]);
            dv_neg  <= vj[fin_idx][DW-1] ^ vk[fin_idx][DW-1];
            dv_zero <= (vk[fin_idx] == '0);
          end
        endcase
      end

      // restoring divide, one quotient bit a cycle
      if (dv_busy) begin
        if (dv_cnt != '0) begin
          dv_cnt <= dv_cnt - 1'b1;
          if (!dv_diff[DW]) begin
            dv_rem <= dv_diff[DW-1:0];
            dv_quo <= {dv_quo[DW-2:0], 1'b1};
          end else begin
            dv_rem <= dv_sh[DW-1:0];
            dv_quo <= {dv_quo[DW-2:0], 1'b0};
          end
        end else begin
          dv_busy <= 1'b0;
          res_dz  <= dv_zero;
          if (dv_zero) res <= '0;
          else if (dv_neg) res <= ~dv_quo + 1'b1;
          else res <= dv_quo;
        end
      end

      // station result goes out
      if (ctl.emit) begin
        busy[sel]          <= 1'b0;
        op[sel]            <= '0;
        fin[sel]           <= 1'b0;
        cnt                <= cnt + 1'b1;
        out_data.kind           <= 1'b1;
        out_data.issue_accepted <= 1'b0;
        out_data.station_tag    <= tac_pkg::tag_of(32'(sel));
        out_data.bus_value      <= res;
        out_data.div_zero       <= res_dz;
        out_data.last           <= ((fin & ~bc_skip) == '0) ||
                                   (cnt == CW'(tac_pkg::MAX_RESULTS - 1));
      end

      // external result goes out
      if (ctl.ext) begin
        out_data.kind           <= 1'b1;
        out_data.issue_accepted <= 1'b0;
        out_data.station_tag    <= req.ext_tag;
        out_data.bus_value      <= req.data_value;
        out_data.div_zero       <= 1'b0;
        out_data.last           <= 1'b1;
      end

      // common data bus: waiting stations and registers capture
      if (bc_en) begin
        for (int i = 0; i < NS; i++) begin
          if (busy[i] && !bc_skip[i]) begin
            if (qj[i] == bc_tag) begin
              vj[i] <= bc_val;
              qj[i] <= '0;
            end
            if (qk[i] == bc_tag) begin
              vk[i] <= bc_val;
              qk[i] <= '0;
            end
          end
        end
        for (int i = 0; i < NUM_REGS; i++) begin
          if (rq[i] == bc_tag) begin
            rv[i] <= bc_val;
            rq[i] <= '0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tomasulo_alu_issue_core_tb.sv
// ----------------------------------------------------------------------------
// tomasulo_alu_issue_core_tb: self-checking bench of the tomasulo alu core
// Drives issue, tick, external broadcast and register write requests with
// random gaps and output stalls, predicts every result from a model of the
// stations and register file, and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tomasulo_alu_issue_core_tb;

  localparam int NST = tac_pkg::DEF_ADD_STATIONS + tac_pkg::DEF_MUL_STATIONS;
  localparam int NADD = tac_pkg::DEF_ADD_STATIONS;
  localparam int LW = tac_pkg::LAT_WIDTH;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tac_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tac_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [LW-1:0] cfg_data = '0;

  tomasulo_alu_issue_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // core model state
  logic [LW-1:0]        lat_m [4];
  logic                 busy_m [NST];
  tac_pkg::alu_op_e     op_m [NST];
  logic [31:0]          vj_m [NST], vk_m [NST];
  logic [3:0]           qj_m [NST], qk_m [NST];
  logic [LW-1:0]        left_m [NST];
  logic [31:0]          rval_m [32];
  logic [3:0]           rprod_m [32];

  tac_pkg::rsp_t rsp_q [$];
  int   n_err = 0;
  longint cycles = 0;
  bit   hold_off = 1'b0;
  bit   stall_on = 1'b1;

  task automatic model_reset();
    lat_m[0] = tac_pkg::DADD; lat_m[1] = tac_pkg::DSUB;
    lat_m[2] = tac_pkg::DMUL; lat_m[3] = tac_pkg::DDIV;
    for (int i = 0; i < NST; i++) begin
      busy_m[i] = 0; op_m[i] = tac_pkg::OP_ADD; vj_m[i] = 0; vk_m[i] = 0;
      qj_m[i] = 0; qk_m[i] = 0; left_m[i] = 0;
    end
    for (int r = 0; r < 32; r++) begin
      rval_m[r] = 0; rprod_m[r] = 0;
    end
  endtask

  function automatic logic [31:0] alu_result(tac_pkg::alu_op_e op, logic [31:0] a,
                                             logic [31:0] b, output logic dz);
    logic [31:0] ma, mb, q;
    dz = 0;
    case (op)
      tac_pkg::OP_ADD: return a + b;
      tac_pkg::OP_SUB: return a - b;
      tac_pkg::OP_MUL: return a * b;
      default: begin
        if (b == 0) begin
          dz = 1;
          return 0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
    endcase
  endfunction

  task automatic bus_update(logic [3:0] tag, logic [31:0] v);
    for (int i = 0; i < NST; i++) if (busy_m[i]) begin
      if (qj_m[i] == tag) begin vj_m[i] = v; qj_m[i] = 0; end
      if (qk_m[i] == tag) begin vk_m[i] = v; qk_m[i] = 0; end
    end
    for (int r = 0; r < 32; r++) if (rprod_m[r] == tag) begin
      rval_m[r] = v; rprod_m[r] = 0;
    end
  endtask

  // expected results of one request, in order
  task automatic predict_core(tac_pkg::req_t q);
    tac_pkg::rsp_t res [$];
    tac_pkg::rsp_t x;
    int lo, hi, s;
    logic fin [NST];
    logic dz;
    logic [31:0] v;
    case (tac_pkg::cmd_e'(q.cmd))
      tac_pkg::CMD_ISSUE: begin
        lo = (q.alu_op < 2) ? 0 : NADD;
        hi = (q.alu_op < 2) ? NADD : NST;
        s = -1;
        for (int i = hi - 1; i >= lo; i--) if (!busy_m[i]) s = i;
        x = '0;
        if (s >= 0) begin
          if (rprod_m[q.src1_reg] != 0) begin vj_m[s] = 0; qj_m[s] = rprod_m[q.src1_reg]; end
          else begin vj_m[s] = rval_m[q.src1_reg]; qj_m[s] = 0; end
          if (q.imm_form) begin vk_m[s] = q.immediate; qk_m[s] = 0; end
          else if (rprod_m[q.src2_reg] != 0) begin
            vk_m[s] = 0; qk_m[s] = rprod_m[q.src2_reg];
          end else begin vk_m[s] = rval_m[q.src2_reg]; qk_m[s] = 0; end
          rprod_m[q.dest_reg] = 4'(s + 1);
          op_m[s] = tac_pkg::alu_op_e'(q.alu_op);
          left_m[s] = lat_m[q.alu_op];
          busy_m[s] = 1;
          x.issue_accepted = 1;
          x.station_tag = 4'(s + 1);
        end
        res.insert(res.size(), x);
      end
      tac_pkg::CMD_TICK: begin
        for (int i = 0; i < NST; i++) begin
          fin[i] = 0;
          if (busy_m[i] && qj_m[i] == 0 && qk_m[i] == 0) begin
            if (left_m[i] > 1) left_m[i]--;
            else begin left_m[i] = 0; fin[i] = 1; end
          end
        end
        for (int i = 0; i < NST; i++) if (fin[i] && res.size() < tac_pkg::MAX_RESULTS) begin
          v = alu_result(op_m[i], vj_m[i], vk_m[i], dz);
          busy_m[i] = 0; op_m[i] = tac_pkg::OP_ADD; vj_m[i] = 0; vk_m[i] = 0;
          bus_update(4'(i + 1), v);
          x = '0; x.kind = 1; x.station_tag = 4'(i + 1); x.bus_value = v; x.div_zero = dz;
          res.insert(res.size(), x);
        end
      end
      tac_pkg::CMD_EXT: if (q.ext_tag != 0) begin
        bus_update(q.ext_tag, q.data_value);
        x = '0; x.kind = 1; x.station_tag = q.ext_tag; x.bus_value = q.data_value;
        res.insert(res.size(), x);
      end
      default: rval_m[q.dest_reg] = q.data_value;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1;
    foreach (res[k]) rsp_q.insert(rsp_q.size(), res[k]);
  endtask

  // short random gap, now and then a long one
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(tac_pkg::req_t q);
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_core(q);
    in_valid <= 1'b0;
    idle_gap();
  endtask

  task automatic wait_drain();
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_latency(tac_pkg::cfg_idx_e idx, logic [LW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lat_m[idx] = v;
    @(posedge clk);
  endtask

  function automatic tac_pkg::req_t make_issue(tac_pkg::alu_op_e op, bit imm, int d, int s1,
                                               int s2, logic [31:0] im);
    tac_pkg::req_t q;
    q = '0;
    q.cmd = tac_pkg::CMD_ISSUE; q.alu_op = op; q.imm_form = imm;
    q.dest_reg = 5'(d); q.src1_reg = 5'(s1); q.src2_reg = 5'(s2); q.immediate = im;
    return q;
  endfunction

  function automatic tac_pkg::req_t make_cmd(tac_pkg::cmd_e c, int d, logic [3:0] t,
                                             logic [31:0] dv);
    tac_pkg::req_t q;
    q = '0;
    q.cmd = c; q.dest_reg = 5'(d); q.ext_tag = t; q.data_value = dv;
    return q;
  endfunction

  task automatic send_ticks(int n);
    repeat (n) send_request(make_cmd(tac_pkg::CMD_TICK, 0, 4'd0, 32'd0));
  endtask

  // extremes of data, divide special cases, chained dependences
  task automatic test_directed();
    send_request(make_cmd(tac_pkg::CMD_REGWR, 1, 4'd0, 32'h8000_0000));
    send_request(make_cmd(tac_pkg::CMD_REGWR, 2, 4'd0, 32'hFFFF_FFFF));
    send_request(make_cmd(tac_pkg::CMD_REGWR, 3, 4'd0, 32'h7FFF_FFFF));
    send_request(make_issue(tac_pkg::OP_DIV, 0, 4, 1, 2, 0));
    send_request(make_issue(tac_pkg::OP_DIV, 1, 5, 3, 0, 0));
    send_request(make_issue(tac_pkg::OP_MUL, 0, 6, 1, 1, 0));
    send_request(make_issue(tac_pkg::OP_ADD, 0, 7, 4, 5, 0));
    send_request(make_issue(tac_pkg::OP_SUB, 1, 8, 7, 0, 32'h8000_0000));
    send_request(make_issue(tac_pkg::OP_ADD, 1, 7, 7, 0, 32'h7FFF_FFFF));
    send_request(make_issue(tac_pkg::OP_ADD, 1, 9, 3, 0, 1));
    send_request(make_cmd(tac_pkg::CMD_EXT, 0, 4'd0, 32'h1234));
    send_request(make_cmd(tac_pkg::CMD_EXT, 0, 4'd15, 32'hDEAD_BEEF));
    send_request(make_cmd(tac_pkg::CMD_EXT, 0, 4'd1, 32'h5555_AAAA));
    send_ticks(20);
    send_request(make_issue(tac_pkg::OP_SUB, 0, 31, 31, 31, 0));
    send_request(make_issue(tac_pkg::OP_DIV, 1, 30, 0, 0, 32'hFFFF_FFFF));
    send_ticks(5);
    wait_drain();
  endtask

  task automatic random_request(int w_issue);
    tac_pkg::req_t q;
    q = '0;
    q.cmd = 2'($urandom_range(0, 3));
    q.alu_op = 2'($urandom_range(0, 3));
    q.imm_form = 1'($urandom_range(0, 1));
    q.dest_reg = 5'($urandom_range(0, 7));
    q.src1_reg = 5'($urandom_range(0, 7));
    q.src2_reg = 5'($urandom_range(0, 7));
    q.immediate = $urandom();
    q.ext_tag = 4'($urandom_range(0, 15));
    q.data_value = $urandom();
    if ($urandom_range(0, 99) < w_issue) q.cmd = tac_pkg::CMD_ISSUE;
    else if ($urandom_range(0, 2) != 0) q.cmd = tac_pkg::CMD_TICK;
    if ($urandom_range(0, 3) == 0) q.immediate = $urandom_range(0, 3) - 1;
    if ($urandom_range(0, 3) == 0) q.data_value = $urandom_range(0, 1) ? 32'h8000_0000 : -1;
    if ($urandom_range(0, 2) == 0) q.ext_tag = 4'($urandom_range(1, NST));
    send_request(q);
  endtask

  // random traffic in phases with different latency settings
  task automatic test_random();
    logic [LW-1:0] s [4][4] = '{'{5'd1, 5'd1, 5'd1, 5'd1}, '{5'd31, 5'd31, 5'd31, 5'd31},
                                '{5'd2, 5'd5, 5'd3, 5'd1}, '{5'd0, 5'd7, 5'd0, 5'd2}};
    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r < 4; r++) write_latency(tac_pkg::cfg_idx_e'(r), s[p][r]);
      repeat (20) random_request(45);
      send_ticks(12);
      wait_drain();
    end
  endtask

  // output held off while requests keep coming, then sender waits for drain; then a phase with no stalls
  task automatic test_backpressure();
    write_latency(tac_pkg::CFG_ADD_LAT, 5'd2);
    write_latency(tac_pkg::CFG_MUL_LAT, 5'd3);
    write_latency(tac_pkg::CFG_DIV_LAT, 5'd4);
    hold_off = 1'b1;
    repeat (15) random_request(60);
    while (hold_off) @(posedge clk);
    send_ticks(8);
    wait_drain();
    stall_on = 1'b0;
    repeat (15) random_request(50);
    send_ticks(12);
    wait_drain();
  endtask

  // receiver stall: random, or a long hold-off when requested
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    tac_pkg::rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (rsp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = rsp_q[0];
        rsp_q.delete(0);
        if (out_data !== e) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %h actual %h", e, out_data);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL tomasulo_alu_issue_core");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (n_err == 0 && rsp_q.size() == 0) begin
      $display("PASS tomasulo_alu_issue_core");
    end else begin
      $display("FAIL tomasulo_alu_issue_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
src/tac_pkg.sv
src/tac_ctrl.sv
src/tac_dp.sv
src/tomasulo_alu_issue_core.sv
tb/sv/tomasulo_alu_issue_core_tb.sv
